// ===== src/prf_pkg.sv =====
// Shared types, constants and saturation helper for the polynomial root finder.
// No dependencies; used by every module in src.
package prf_pkg;

   localparam int MAX_DEGREE   = 8;
   localparam int IDX_W        = $clog2(MAX_DEGREE + 1);
   localparam int TERM_W       = IDX_W + 33;
   localparam int HYBRID_STEPS = 5;

   localparam logic [19:0] RESET_MAX_ITER = 20'd10000;
   localparam logic [3:0]  RESET_DEGREE   = 4'd1;

   localparam logic [1:0] M_BISECT = 2'd0;
   localparam logic [1:0] M_NEWTON = 2'd1;
   localparam logic [1:0] M_SECANT = 2'd2;
   localparam logic [1:0] M_HYBRID = 2'd3;

   localparam logic [1:0] CSR_METHOD   = 2'd0;
   localparam logic [1:0] CSR_MAX_ITER = 2'd1;
   localparam logic [1:0] CSR_DEGREE   = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_SOLVE = 1'b1;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic        ovf;
      logic [31:0] val;
   } sat_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] idx;
      logic [31:0]      data;
   } coef_wr_type;

   typedef struct packed {
      logic        start;
      logic        deriv;
      logic [31:0] x;
   } eval_cmd_type;

   typedef struct packed {
      logic        done;
      logic        ovf;
      logic [31:0] value;
   } eval_rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] mul_a;
      logic [32:0] mul_b;
      logic [31:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic        ok;
      logic [31:0] quot;
   } div_rsp_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type s;
      s.ovf = 1'b0;
      if (v > S32_MAX) begin
         s.ovf = 1'b1;
         s.val = 32'h7FFF_FFFF;
      end else if (v < S32_MIN) begin
         s.ovf = 1'b1;
         s.val = 32'h8000_0000;
      end else begin
         s.val = v[31:0];
      end
      return s;
   endfunction

endpackage

// ===== src/polynomial_root_finder.sv =====
// Polynomial root finder: bisection, Newton, secant or hybrid in saturating Q16.16.
// Top level sequencer; instantiates prf_eval and prf_div, depends on prf_pkg.
// Solve time grows with the degree and with the iteration count. One item at a time:
// req_tready is low while a solve runs. Synchronous active-high reset restores
// register defaults; the coefficient store is not cleared.
module polynomial_root_finder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // coef_index[3:0], coef_value, point_a, point_b, pad
   input  logic         req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,  // root[31:0], iteration_total[19:0], converged, pad
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [19:0]  csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOOP = 4'd1;
   localparam logic [3:0] S_BCHK = 4'd2;
   localparam logic [3:0] S_BFA  = 4'd3;
   localparam logic [3:0] S_BF3  = 4'd4;
   localparam logic [3:0] S_NCHK = 4'd5;
   localparam logic [3:0] S_NEXT = 4'd6;
   localparam logic [3:0] S_NEW1 = 4'd7;
   localparam logic [3:0] S_NEW2 = 4'd8;
   localparam logic [3:0] S_SEC1 = 4'd9;
   localparam logic [3:0] S_SEC2 = 4'd10;
   localparam logic [3:0] S_DIV  = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [1:0]  method_ff;
   logic [19:0] maxit_ff;
   logic [3:0]  degree_ff;

   logic [3:0]  state_ff, state_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] x3_ff, x3_in;
   logic [19:0] it_ff, it_in;
   logic [1:0]  am_ff, am_in;
   logic [31:0] f1_ff, f1_in;
   logic [31:0] f2_ff, f2_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] res_root_ff, res_root_in;
   logic        res_ok_ff, res_ok_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_root_ff, out_root_in;
   logic [19:0] out_it_ff, out_it_in;
   logic        out_ok_ff, out_ok_in;

   logic [3:0]  in_idx;
   logic [31:0] in_coef, in_pa, in_pb;
   logic        req_xfer;

   logic [32:0] mid_sum, den33, step33;
   logic        opp_sign;
   logic [prf_pkg::IDX_W-1:0] deg_used;

   prf_pkg::coef_wr_type  coef_wr;
   prf_pkg::eval_cmd_type eval_cmd;
   prf_pkg::eval_rsp_type eval_rsp;
   prf_pkg::div_cmd_type  div_cmd;
   prf_pkg::div_rsp_type  div_rsp;

   assign in_idx   = req_tdata[3:0];
   assign in_coef  = req_tdata[35:4];
   assign in_pa    = req_tdata[67:36];
   assign in_pb    = req_tdata[99:68];
   assign req_xfer = req_tvalid & req_tready;

   assign deg_used = (degree_ff > 4'(prf_pkg::MAX_DEGREE))
                     ? prf_pkg::IDX_W'(prf_pkg::MAX_DEGREE)
                     : prf_pkg::IDX_W'(degree_ff);

   assign coef_wr.we   = req_xfer && (req_tuser == prf_pkg::REQ_LOAD)
                         && (32'(in_idx) <= 32'(prf_pkg::MAX_DEGREE));
   assign coef_wr.idx  = prf_pkg::IDX_W'(in_idx);
   assign coef_wr.data = in_coef;

   prf_eval u_eval (
      .clock  (clock),
      .reset  (reset),
      .coef_wr(coef_wr),
      .degree (deg_used),
      .cmd    (eval_cmd),
      .rsp    (eval_rsp)
   );

   prf_div u_div (
      .clock(clock),
      .reset(reset),
      .cmd  (div_cmd),
      .rsp  (div_rsp)
   );

   assign mid_sum  = {a_ff[31], a_ff} + {b_ff[31], b_ff};
   assign den33    = {eval_rsp.value[31], eval_rsp.value} - {f1_ff[31], f1_ff};
   assign step33   = {b_ff[31], b_ff} - {div_rsp.quot[31], div_rsp.quot};
   assign opp_sign = ($signed(f1_ff) < 0 && $signed(eval_rsp.value) > 0)
                     || ($signed(f1_ff) > 0 && $signed(eval_rsp.value) < 0);

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      x3_in        = x3_ff;
      it_in        = it_ff;
      am_in        = am_ff;
      f1_in        = f1_ff;
      f2_in        = f2_ff;
      ovf_in       = ovf_ff;
      res_root_in  = res_root_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      out_root_in  = out_root_ff;
      out_it_in    = out_it_ff;
      out_ok_in    = out_ok_ff;
      eval_cmd     = '0;
      div_cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_tuser == prf_pkg::REQ_SOLVE) begin
               am_in    = method_ff;
               it_in    = '0;
               a_in     = in_pa;
               b_in     = (method_ff == prf_pkg::M_NEWTON) ? in_pa : in_pb;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (it_ff >= maxit_ff) begin
               res_root_in = b_ff;
               res_ok_in   = 1'b0;
               state_in    = S_DONE;
            end else if (am_ff == prf_pkg::M_SECANT) begin
               eval_cmd.start = 1'b1;
               eval_cmd.x     = a_ff;
               state_in       = S_SEC1;
            end else if (am_ff == prf_pkg::M_NEWTON) begin
               eval_cmd.start = 1'b1;
               eval_cmd.x     = b_ff;
               state_in       = S_NEW1;
            end else begin
               x3_in = mid_sum[32:1];
               if (am_ff == prf_pkg::M_BISECT || it_ff < 20'(prf_pkg::HYBRID_STEPS)) begin
                  state_in = S_BCHK;
               end else begin
                  state_in = S_NCHK;
               end
            end
         end
         S_BCHK: begin
            if (x3_ff == a_ff || x3_ff == b_ff) begin
               res_root_in = x3_ff;
               res_ok_in   = 1'b1;
               state_in    = S_DONE;
            end else begin
               eval_cmd.start = 1'b1;
               eval_cmd.x     = a_ff;
               state_in       = S_BFA;
            end
         end
         S_BFA: begin
            if (eval_rsp.done) begin
               f1_in          = eval_rsp.value;
               eval_cmd.start = 1'b1;
               eval_cmd.x     = x3_ff;
               state_in       = S_BF3;
            end
         end
         S_BF3: begin
            if (eval_rsp.done) begin
               if (opp_sign) begin
                  b_in = x3_ff;
               end else begin
                  a_in = x3_ff;
               end
               state_in = S_NEXT;
            end
         end
         S_NCHK: begin
            if (x3_ff == b_ff) begin
               res_root_in = x3_ff;
               res_ok_in   = 1'b1;
               state_in    = S_DONE;
            end else begin
               a_in     = b_ff;
               b_in     = x3_ff;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (am_ff == prf_pkg::M_HYBRID && it_ff >= 20'(prf_pkg::HYBRID_STEPS)) begin
               am_in = prf_pkg::M_NEWTON;
            end
            it_in    = it_ff + 1'b1;
            state_in = S_LOOP;
         end
         S_NEW1: begin
            if (eval_rsp.done) begin
               f2_in          = eval_rsp.value;
               ovf_in         = eval_rsp.ovf;
               eval_cmd.start = 1'b1;
               eval_cmd.deriv = 1'b1;
               eval_cmd.x     = b_ff;
               state_in       = S_NEW2;
            end
         end
         S_NEW2: begin
            if (eval_rsp.done) begin
               if (ovf_ff || eval_rsp.ovf || eval_rsp.value == '0) begin
                  res_root_in = b_ff;
                  res_ok_in   = 1'b0;
                  state_in    = S_DONE;
               end else begin
                  div_cmd.start = 1'b1;
                  div_cmd.mul_a = f2_ff;
                  div_cmd.mul_b = 33'd65536;
                  div_cmd.den   = eval_rsp.value;
                  state_in      = S_DIV;
               end
            end
         end
         S_SEC1: begin
            if (eval_rsp.done) begin
               f1_in          = eval_rsp.value;
               ovf_in         = eval_rsp.ovf;
               eval_cmd.start = 1'b1;
               eval_cmd.x     = b_ff;
               state_in       = S_SEC2;
            end
         end
         S_SEC2: begin
            if (eval_rsp.done) begin
               if (ovf_ff || eval_rsp.ovf || den33 == '0 || den33[32] != den33[31]) begin
                  res_root_in = b_ff;
                  res_ok_in   = 1'b0;
                  state_in    = S_DONE;
               end else begin
                  div_cmd.start = 1'b1;
                  div_cmd.mul_a = eval_rsp.value;
                  div_cmd.mul_b = {b_ff[31], b_ff} - {a_ff[31], a_ff};
                  div_cmd.den   = den33[31:0];
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (!div_rsp.ok || step33[32] != step33[31]) begin
                  res_root_in = b_ff;
                  res_ok_in   = 1'b0;
                  state_in    = S_DONE;
               end else begin
                  x3_in    = step33[31:0];
                  state_in = S_NCHK;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_root_in  = res_root_ff;
               out_it_in    = it_ff;
               out_ok_in    = res_ok_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         method_ff    <= prf_pkg::M_BISECT;
         maxit_ff     <= prf_pkg::RESET_MAX_ITER;
         degree_ff    <= prf_pkg::RESET_DEGREE;
         it_ff        <= '0;
         am_ff        <= prf_pkg::M_BISECT;
         a_ff         <= '0;
         b_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         it_ff        <= it_in;
         am_ff        <= am_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         if (csr_we) begin
            case (csr_index)
               prf_pkg::CSR_METHOD:   method_ff <= csr_wdata[1:0];
               prf_pkg::CSR_MAX_ITER: maxit_ff  <= csr_wdata;
               prf_pkg::CSR_DEGREE:   degree_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x3_ff       <= x3_in;
      f1_ff       <= f1_in;
      f2_ff       <= f2_in;
      ovf_ff      <= ovf_in;
      res_root_ff <= res_root_in;
      res_ok_ff   <= res_ok_in;
      out_root_ff <= out_root_in;
      out_it_ff   <= out_it_in;
      out_ok_ff   <= out_ok_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_ok_ff, out_it_ff, out_root_ff};

   a_next_below_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NEXT |-> it_ff < maxit_ff)
      else $error("iteration advanced at or beyond the limit");

   a_eval_done_expected: assert property (@(posedge clock) disable iff (reset)
      eval_rsp.done |-> (state_ff == S_BFA || state_ff == S_BF3 || state_ff == S_NEW1
                         || state_ff == S_NEW2 || state_ff == S_SEC1 || state_ff == S_SEC2))
      else $error("evaluator finished while no step waits for it");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished while no step waits for it");

   a_hybrid_switched: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOP && it_ff > 20'(prf_pkg::HYBRID_STEPS)) |-> am_ff != prf_pkg::M_HYBRID)
      else $error("hybrid solve did not switch to Newton");

endmodule

// ===== src/prf_eval.sv =====
// Horner evaluator for the polynomial or its derivative, one multiply per step (two for the derivative).
// Holds the coefficient store. Depends on prf_pkg.
module prf_eval (
   input  logic                       clock,
   input  logic                       reset,
   input  prf_pkg::coef_wr_type       coef_wr,
   input  logic [prf_pkg::IDX_W-1:0]  degree,
   input  prf_pkg::eval_cmd_type      cmd,
   output prf_pkg::eval_rsp_type      rsp
);

   localparam logic [1:0] E_IDLE = 2'd0;
   localparam logic [1:0] E_MUL  = 2'd1;
   localparam logic [1:0] E_ADD  = 2'd2;
   localparam logic [1:0] E_DONE = 2'd3;

   logic [31:0] coef_mem [0:prf_pkg::MAX_DEGREE];

   logic [1:0]                  state_ff, state_in;
   logic [31:0]                 r_ff, r_in;
   logic [31:0]                 x_ff, x_in;
   logic [prf_pkg::IDX_W-1:0]   p_ff, p_in;
   logic                        deriv_ff, deriv_in;
   logic                        ovf_ff, ovf_in;
   logic signed [63:0]          prod_ff, prod_in;
   logic signed [prf_pkg::TERM_W-1:0] term_ff, term_in;

   logic [31:0]                 coef_rd;
   prf_pkg::sat_type            qs, ts, ss;

   always_ff @(posedge clock) begin
      if (coef_wr.we) begin
         coef_mem[coef_wr.idx] <= coef_wr.data;
      end
   end

   assign coef_rd = coef_mem[p_ff];

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      p_in     = p_ff;
      deriv_in = deriv_ff;
      ovf_in   = ovf_ff;
      prod_in  = prod_ff;
      term_in  = term_ff;
      qs = prf_pkg::sat32(prod_ff >>> 16);
      ts = prf_pkg::sat32(64'(term_ff));
      ss = prf_pkg::sat32(64'($signed(qs.val)) + 64'($signed(ts.val)));
      case (state_ff)
         E_IDLE, E_DONE: begin
            state_in = E_IDLE;
            if (cmd.start) begin
               r_in     = '0;
               ovf_in   = 1'b0;
               x_in     = cmd.x;
               p_in     = degree;
               deriv_in = cmd.deriv;
               state_in = (cmd.deriv && degree == '0) ? E_DONE : E_MUL;
            end
         end
         E_MUL: begin
            prod_in = $signed(r_ff) * $signed(x_ff);
            if (deriv_ff) begin
               term_in = $signed({1'b0, p_ff}) * $signed(coef_rd);
            end else begin
               term_in = prf_pkg::TERM_W'($signed(coef_rd));
            end
            state_in = E_ADD;
         end
         E_ADD: begin
            r_in   = ss.val;
            ovf_in = ovf_ff | qs.ovf | ts.ovf | ss.ovf;
            if (p_ff == prf_pkg::IDX_W'(deriv_ff)) begin
               state_in = E_DONE;
            end else begin
               p_in     = p_ff - 1'b1;
               state_in = E_MUL;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      x_ff     <= x_in;
      p_ff     <= p_in;
      deriv_ff <= deriv_in;
      ovf_ff   <= ovf_in;
      prod_ff  <= prod_in;
      term_ff  <= term_in;
   end

   assign rsp.done  = (state_ff == E_DONE);
   assign rsp.ovf   = ovf_ff;
   assign rsp.value = r_ff;

endmodule

// ===== src/prf_div.sv =====
// Multiply then restoring divide, one quotient bit per cycle, truncating toward zero.
// Reports whether the quotient fits 32 signed bits. Depends on prf_pkg.
module prf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  prf_pkg::div_cmd_type cmd,
   output prf_pkg::div_rsp_type rsp
);

   localparam logic [2:0] D_IDLE = 3'd0;
   localparam logic [2:0] D_MUL  = 3'd1;
   localparam logic [2:0] D_ABS  = 3'd2;
   localparam logic [2:0] D_RUN  = 3'd3;
   localparam logic [2:0] D_DONE = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [31:0]        a_ff, a_in;
   logic [32:0]        b_ff, b_in;
   logic [31:0]        dmag_ff, dmag_in;
   logic               dneg_ff, dneg_in;
   logic               neg_ff, neg_in;
   logic signed [64:0] prod_ff, prod_in;
   logic [63:0]        mag_ff, mag_in;
   logic [31:0]        rem_ff, rem_in;

   logic [64:0]        prod_abs;
   logic [32:0]        trial, diff;
   logic               ge;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      dmag_in  = dmag_ff;
      dneg_in  = dneg_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      prod_abs = prod_ff[64] ? (65'd0 - 65'(prod_ff)) : 65'(prod_ff);
      trial    = {rem_ff, mag_ff[63]};
      ge       = (trial >= {1'b0, dmag_ff});
      diff     = trial - {1'b0, dmag_ff};
      case (state_ff)
         D_IDLE: begin
            if (cmd.start) begin
               a_in     = cmd.mul_a;
               b_in     = cmd.mul_b;
               dneg_in  = cmd.den[31];
               dmag_in  = cmd.den[31] ? (32'd0 - cmd.den) : cmd.den;
               state_in = D_MUL;
            end
         end
         D_MUL: begin
            prod_in  = $signed(a_ff) * $signed(b_ff);
            state_in = D_ABS;
         end
         D_ABS: begin
            mag_in   = prod_abs[63:0];
            neg_in   = prod_ff[64] ^ dneg_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = D_RUN;
         end
         D_RUN: begin
            rem_in = ge ? diff[31:0] : trial[31:0];
            mag_in = {mag_ff[62:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) begin
               state_in = D_DONE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      dmag_ff <= dmag_in;
      dneg_ff <= dneg_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
   end

   assign rsp.done = (state_ff == D_DONE);
   assign rsp.ok   = neg_ff ? (mag_ff <= 64'h8000_0000) : (mag_ff <= 64'h7FFF_FFFF);
   assign rsp.quot = neg_ff ? (32'd0 - mag_ff[31:0]) : mag_ff[31:0];

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for polynomial_root_finder: coefficient loads and
// solves over all methods, predicted in Q16.16 and compared per transfer.
// Depends on prf_pkg and the RTL in src.
module testbench;

   localparam longint LIMIT = 20000000;

   typedef struct {
      logic              kind;
      logic [3:0]        idx;
      logic signed [31:0] val;
      logic signed [31:0] pa;
      logic signed [31:0] pb;
   } req_item_type;

   typedef struct {
      logic signed [31:0] root;
      logic [19:0]        iters;
      logic               conv;
   } root_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;  // coef_index[3:0], coef_value, point_a, point_b, pad
   logic         req_tuser = 1'b0; // req_type
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;      // root[31:0], iteration_total[19:0], converged, pad
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [19:0]  csr_wdata = '0;

   req_item_type    pending_reqs[$];
   root_result_type expected_roots[$];
   int              errors = 0;
   longint          cycles = 0;
   bit              calm = 1'b0;

   logic signed [31:0] coefs[0:prf_pkg::MAX_DEGREE];
   logic [1:0]         cur_method;
   logic [19:0]        cur_max_iter;
   logic [3:0]         cur_degree;

   polynomial_root_finder i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[polynomial_root_finder] ERROR");
         $finish;
      end
   end

   function automatic int sat_q(longint v, inout bit ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return int'(v);
   endfunction

   function automatic bit fits_q(longint v);
      return v >= -64'sd2147483648 && v <= 64'sd2147483647;
   endfunction

   function automatic int mul_q(int a, int b, inout bit ovf);
      return sat_q((longint'(a) * longint'(b)) >>> 16, ovf);
   endfunction

   function automatic int eff_degree();
      return (cur_degree > prf_pkg::MAX_DEGREE) ? prf_pkg::MAX_DEGREE : int'(cur_degree);
   endfunction

   function automatic int horner_f(int x, inout bit ovf);
      int r;
      r = 0;
      for (int p = eff_degree(); p >= 0; p--)
         r = sat_q(longint'(mul_q(r, x, ovf)) + longint'(coefs[p]), ovf);
      return r;
   endfunction

   function automatic int horner_df(int x, inout bit ovf);
      int r;
      int term;
      r = 0;
      for (int p = eff_degree(); p >= 1; p--) begin
         term = sat_q(longint'(p) * longint'(coefs[p]), ovf);
         r = sat_q(longint'(mul_q(r, x, ovf)) + longint'(term), ovf);
      end
      return r;
   endfunction

   function automatic bit newton_next(int x2, output int x3);
      bit     ovf;
      int     f2, d2;
      longint q, n;
      ovf = 1'b0;
      x3 = 0;
      f2 = horner_f(x2, ovf);
      d2 = horner_df(x2, ovf);
      if (ovf || d2 == 0) return 1'b0;
      q = (longint'(f2) * 65536) / longint'(d2);
      if (!fits_q(q)) return 1'b0;
      n = longint'(x2) - q;
      if (!fits_q(n)) return 1'b0;
      x3 = int'(n);
      return 1'b1;
   endfunction

   function automatic bit secant_next(int x1, int x2, output int x3);
      bit     ovf;
      int     f1, f2;
      longint den, q, n;
      ovf = 1'b0;
      x3 = 0;
      f1 = horner_f(x1, ovf);
      f2 = horner_f(x2, ovf);
      den = longint'(f2) - longint'(f1);
      if (ovf || den == 0 || !fits_q(den)) return 1'b0;
      q = (longint'(f2) * (longint'(x2) - longint'(x1))) / den;
      if (!fits_q(q)) return 1'b0;
      n = longint'(x2) - q;
      if (!fits_q(n)) return 1'b0;
      x3 = int'(n);
      return 1'b1;
   endfunction

   function automatic root_result_type find_root(int pa, int pb);
      root_result_type res;
      logic [1:0] m;
      int  a, b, x3, fa, f3, cnt;
      bit  ok, stop, good, bis, dummy;
      m = cur_method;
      cnt = 0;
      a = pa;
      b = (m == prf_pkg::M_NEWTON) ? pa : pb;
      ok = 1'b0;
      stop = 1'b0;
      res.root = b;
      while (!stop && cnt < int'(cur_max_iter)) begin
         bis = (m == prf_pkg::M_BISECT)
               || (m == prf_pkg::M_HYBRID && cnt < prf_pkg::HYBRID_STEPS);
         good = 1'b1;
         x3 = 0;
         if (m == prf_pkg::M_BISECT || m == prf_pkg::M_HYBRID)
            x3 = int'((longint'(a) + longint'(b)) >>> 1);
         else if (m == prf_pkg::M_SECANT)
            good = secant_next(a, b, x3);
         else
            good = newton_next(b, x3);
         if (!good) begin
            stop = 1'b1;
         end else if (bis) begin
            if (x3 == a || x3 == b) begin
               ok = 1'b1;
               stop = 1'b1;
               res.root = x3;
            end else begin
               dummy = 1'b0;
               fa = horner_f(a, dummy);
               f3 = horner_f(x3, dummy);
               if ((fa < 0 && f3 > 0) || (fa > 0 && f3 < 0)) b = x3;
               else a = x3;
            end
         end else begin
            if (x3 == b) begin
               ok = 1'b1;
               stop = 1'b1;
               res.root = x3;
            end else begin
               a = b;
               b = x3;
            end
         end
         if (!stop) begin
            if (m == prf_pkg::M_HYBRID && cnt >= prf_pkg::HYBRID_STEPS) m = prf_pkg::M_NEWTON;
            cnt++;
         end
      end
      if (!ok) res.root = b;
      res.iters = cnt[19:0];
      res.conv = ok;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
            it = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= it.kind;
            req_tdata <= {4'b0, it.pb, it.pa, it.val, it.idx};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      root_result_type want;
      logic [3:0] ix;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= 21;
         if (req_tvalid && req_tready) begin
            ix = req_tdata[3:0];
            if (req_tuser == prf_pkg::REQ_LOAD) begin
               if (ix <= prf_pkg::MAX_DEGREE) coefs[ix] = req_tdata[35:4];
            end else begin
               expected_roots.insert(expected_roots.size(),
                                     find_root(req_tdata[67:36], req_tdata[99:68]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_roots.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata[31:0], 32'h0);
            end else begin
               want = expected_roots.pop_front();
               if (rsp_tdata[31:0] !== want.root)
                  report_mismatch("root", rsp_tdata[31:0], want.root);
               if (rsp_tdata[51:32] !== want.iters)
                  report_mismatch("iteration_total", 32'(rsp_tdata[51:32]), 32'(want.iters));
               if (rsp_tdata[52] !== want.conv)
                  report_mismatch("converged", 32'(rsp_tdata[52]), 32'(want.conv));
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_fix(int span);
      if ($urandom_range(9) == 0) return $urandom;
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic push_load(logic [3:0] ix, logic signed [31:0] v);
      req_item_type it;
      it.kind = prf_pkg::REQ_LOAD;
      it.idx = ix;
      it.val = v;
      it.pa = $urandom;
      it.pb = $urandom;
      pending_reqs.insert(pending_reqs.size(), it);
   endtask

   task automatic push_solve(logic signed [31:0] pa, logic signed [31:0] pb);
      req_item_type it;
      it.kind = prf_pkg::REQ_SOLVE;
      it.idx = 4'($urandom);
      it.val = $urandom;
      it.pa = pa;
      it.pb = pb;
      pending_reqs.insert(pending_reqs.size(), it);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_roots.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] ix, logic [19:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= ix;
      csr_wdata <= v;
      if (ix == prf_pkg::CSR_METHOD) cur_method = v[1:0];
      else if (ix == prf_pkg::CSR_MAX_ITER) cur_max_iter = v;
      else if (ix == prf_pkg::CSR_DEGREE) cur_degree = v[3:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [1:0]  m;
      logic [19:0] lim;
      cur_method = prf_pkg::M_BISECT;
      cur_max_iter = prf_pkg::RESET_MAX_ITER;
      cur_degree = prf_pkg::RESET_DEGREE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, bisection, field extremes
      for (int i = 0; i <= prf_pkg::MAX_DEGREE; i++) push_load(4'(i), 32'sh8000_0000);
      push_solve(32'sh8000_0000, 32'sh7FFF_FFFF);
      push_load(4'd0, 32'sh7FFF_FFFF);
      push_load(4'd9, 32'sh1234_5678);
      push_load(4'd15, 32'shFFFF_FFFF);
      push_solve(32'sh7FFF_FFFF, 32'sh8000_0000);
      push_load(4'd0, -32'sh0002_0000);
      push_load(4'd1, 32'sh0001_0000);
      push_solve(32'sh0000_0000, 32'sh0004_0000);
      push_solve(32'sh0001_0000, 32'sh0001_0000);
      push_solve(32'sh0001_0000, 32'sh0001_0001);
      push_solve(32'shFFFF_FFFF, 32'sh0000_0000);
      push_solve(32'sh8000_0000, 32'sh8000_0000);
      drain();

      for (int ph = 0; ph < 14; ph++) begin
         m = ph[1:0];
         if (m == prf_pkg::M_BISECT)
            case ($urandom_range(4))
               0: lim = 20'd0;
               1: lim = 20'hFFFFF;
               2: lim = prf_pkg::RESET_MAX_ITER;
               default: lim = 20'($urandom_range(1, 40));
            endcase
         else
            lim = ($urandom_range(7) == 0) ? 20'd0 : 20'($urandom_range(1, 30));
         write_reg(prf_pkg::CSR_METHOD, 20'(m));
         write_reg(prf_pkg::CSR_MAX_ITER, lim);
         write_reg(prf_pkg::CSR_DEGREE,
                   (ph == 1) ? 20'd8 : (ph == 2) ? 20'd1 : 20'($urandom_range(1, 8)));
         calm = (ph == 6);
         for (int i = 0; i <= prf_pkg::MAX_DEGREE; i++)
            push_load(4'(i), rand_fix(32'h0004_0000));
         for (int n = 0; n < 33; n++) begin
            if ($urandom_range(3) == 0)
               push_load(4'($urandom_range(15)), rand_fix(32'h0004_0000));
            else
               push_solve(rand_fix(32'h0010_0000), rand_fix(32'h0010_0000));
         end
         drain();
      end

      if (errors == 0) begin
         $display("[polynomial_root_finder] OK");
      end else begin
         $display("[polynomial_root_finder] ERROR");
      end
      $finish;
   end

endmodule
